### sv/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the palette subpixel downscaler.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Configuration register indexes, taken from paddr[2].
  localparam logic RegScaleMode     = 1'b0;
  localparam logic RegOverlayEnable = 1'b1;

  // Scale modes.
  localparam logic ModeSubpixel = 1'b0;
  localparam logic ModePacked   = 1'b1;

  // Input opcodes.
  localparam logic OpPixel    = 1'b0;
  localparam logic OpPalWrite = 1'b1;

  // Division by three of a sum below 2048: (n * 683) >> 11 is exact.
  localparam int unsigned Div3Mul   = 683;
  localparam int unsigned Div3Shift = 11;

  // Number of gathered source indexes per pixel word (3 columns by 3 rows).
  localparam int unsigned NumSrc = 9;

  // One palette entry in RGB888, red in the low byte.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pal_entry_t;

  // Overlay word in ABGR order from the top byte down, red in the low byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } ovl_t;

endpackage

### sv/psd_ram.sv
// ----------------------------------------------------------------------------
// psd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module psd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/psd_lane.sv
// ----------------------------------------------------------------------------
// psd_lane
// One color column: sums three row samples and divides the sum by three.
// ----------------------------------------------------------------------------
module psd_lane (
  input  logic       clk_i,
  input  logic       ld_i,
  input  logic [7:0] row0_i,
  input  logic [7:0] row1_i,
  input  logic [7:0] row2_i,
  output logic [7:0] avg_o
);

  logic [9:0]  sum;
  logic [19:0] prod;
  logic [7:0]  avg_q;

  // Three-row sum, then division by three through a reciprocal multiply.
  always_comb begin
    sum  = 10'(row0_i) + 10'(row1_i) + 10'(row2_i);
    prod = 20'(sum) * 20'(psd_pkg::Div3Mul);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      avg_q <= prod[psd_pkg::Div3Shift +: 8];
    end
  end

  assign avg_o = avg_q;

endmodule

### sv/psd_merge.sv
// ----------------------------------------------------------------------------
// psd_merge
// Combines the lane averages into RGB565 and builds the packed 2x2 average.
// ----------------------------------------------------------------------------
module psd_merge (
  input  logic                clk_i,
  input  logic                ld_i,
  input  logic                mode_i,
  input  psd_pkg::pal_entry_t e00_i,
  input  psd_pkg::pal_entry_t e10_i,
  input  psd_pkg::pal_entry_t e01_i,
  input  psd_pkg::pal_entry_t e11_i,
  input  logic [7:0]          avg_r_i,
  input  logic [7:0]          avg_g_i,
  input  logic [7:0]          avg_b_i,
  output logic [15:0]         col_o
);

  logic [15:0] h0a, h0b, h1a, h1b;
  logic [17:0] psum;
  logic [15:0] packed_q;

  // Half-palette words: red and green for column 0, green and blue for column 1.
  always_comb begin
    h0a  = {e00_i.red[7:3], 1'b0, e00_i.green[7:3], 5'b0};
    h0b  = {e01_i.red[7:3], 1'b0, e01_i.green[7:3], 5'b0};
    h1a  = {6'b0, e10_i.green[7:3], e10_i.blue[7:3]};
    h1b  = {6'b0, e11_i.green[7:3], e11_i.blue[7:3]};
    psum = 18'(h0a) + 18'(h1a) + 18'(h0b) + 18'(h1b);
  end

  // Packed average; carries between fields are kept as the sum gives them.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      packed_q <= psum[17:2];
    end
  end

  // Mode select between the subpixel composite and the packed average.
  always_comb begin
    unique case (mode_i)
      psd_pkg::ModePacked:   col_o = packed_q;
      default:               col_o = {avg_r_i[7:3], avg_g_i[7:2], avg_b_i[7:3]};
    endcase
  end

endmodule

### sv/psd_blend.sv
// ----------------------------------------------------------------------------
// psd_blend
// Blends an RGB565 pixel with the overlay color at alpha a/2+128.
// ----------------------------------------------------------------------------
module psd_blend (
  input  logic          clk_i,
  input  logic          ld_i,
  input  logic          enable_i,
  input  logic [15:0]   col_i,
  input  psd_pkg::ovl_t ovl_i,
  output logic [15:0]   pixel_o
);

  logic [7:0]  alpha;
  logic [8:0]  inv;
  logic [7:0]  br, bg, bb;
  logic [15:0] pr_base_q, pg_base_q, pb_base_q;
  logic [15:0] pr_ovl_q, pg_ovl_q, pb_ovl_q;
  logic [15:0] col_q;
  logic [16:0] r, g, b;
  logic [17:0] bsum;

  // Expand the pixel and force the alpha.
  always_comb begin
    alpha = {1'b1, ovl_i.alpha[7:1]};
    inv   = 9'd256 - {1'b0, alpha};
    br    = {col_i[15:11], 3'b0};
    bg    = {col_i[10:5], 2'b0};
    bb    = {col_i[4:0], 3'b0};
  end

  // Product stage: base and overlay weights for each channel.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      pr_base_q <= 16'(17'(br) * 17'(inv));
      pg_base_q <= 16'(17'(bg) * 17'(inv));
      pb_base_q <= 16'(17'(bb) * 17'(inv));
      pr_ovl_q  <= 16'(16'(ovl_i.red) * 16'(alpha));
      pg_ovl_q  <= 16'(16'(ovl_i.green) * 16'(alpha));
      pb_ovl_q  <= 16'(16'(ovl_i.blue) * 16'(alpha));
      col_q     <= col_i;
    end
  end

  // Channel sums and repacking; overflow runs into the next field up.
  always_comb begin
    r    = 17'(pr_base_q) + 17'(pr_ovl_q);
    g    = 17'(pg_base_q) + 17'(pg_ovl_q);
    b    = 17'(pb_base_q) + 17'(pb_ovl_q);
    bsum = 18'({r[16:11], 11'b0}) + 18'({g[16:10], 5'b0}) + 18'(b[16:11]);
    pixel_o = enable_i ? bsum[15:0] : col_q;
  end

endmodule

### sv/palette_subpixel_downscaler_top.sv
// ----------------------------------------------------------------------------
// palette_subpixel_downscaler_top
// Palette lookup, 3x3 subpixel or 2x2 packed averaging, overlay blend and
// byte-swapped RGB565 output, with an APB-style configuration port.
// ----------------------------------------------------------------------------
// Stages: palette read, lane and packed averages, blend products, output register.
// Throughput: one word per cycle unless the output stalls; nine palette copies
// read all indexes at once. Palette-write words produce no output.
// Reset clears the pipeline valid flags and both configuration registers.
// The palette has no reset; an entry holds garbage until it is written.
// ----------------------------------------------------------------------------
module palette_subpixel_downscaler_top #(
  parameter int unsigned PALETTE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input word channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  src_c0_r0_i,
  input  logic [7:0]  src_c1_r0_i,
  input  logic [7:0]  src_c2_r0_i,
  input  logic [7:0]  src_c0_r1_i,
  input  logic [7:0]  src_c1_r1_i,
  input  logic [7:0]  src_c2_r1_i,
  input  logic [7:0]  src_c0_r2_i,
  input  logic [7:0]  src_c1_r2_i,
  input  logic [7:0]  src_c2_r2_i,
  input  logic [31:0] overlay_word_i,
  // Output word channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] pixel_out_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  logic                scale_mode_q, overlay_enable_q;
  logic [7:0]          src [psd_pkg::NumSrc];
  logic [AddrW-1:0]    raddr [psd_pkg::NumSrc];
  logic [AddrW-1:0]    waddr;
  logic [23:0]         rdata [psd_pkg::NumSrc];
  psd_pkg::pal_entry_t ent [psd_pkg::NumSrc];
  logic                in_acc, pal_we;
  logic                ld1, ld2, ld3, ld4;
  logic                v1_q, v2_q, v3_q, vo_q;
  psd_pkg::ovl_t       ovl1_q, ovl2_q;
  logic [7:0]          avg [3];
  logic [15:0]         col, pix;
  logic [15:0]         pixel_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mode_q     <= 1'b0;
      overlay_enable_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        psd_pkg::RegScaleMode:     scale_mode_q     <= pwdata[0];
        psd_pkg::RegOverlayEnable: overlay_enable_q <= pwdata[0];
        default:                   scale_mode_q     <= scale_mode_q;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = {31'b0, (paddr[2] == psd_pkg::RegOverlayEnable) ? overlay_enable_q
                                                                   : scale_mode_q};

  // Stage advance: a stage loads when it is empty or its successor moves.
  assign ld4        = !vo_q || out_ready_i;
  assign ld3        = !v3_q || ld4;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pal_we     = in_acc && (opcode_i == psd_pkg::OpPalWrite);

  // Gathered indexes in row-major order.
  assign src[0] = src_c0_r0_i;
  assign src[1] = src_c1_r0_i;
  assign src[2] = src_c2_r0_i;
  assign src[3] = src_c0_r1_i;
  assign src[4] = src_c1_r1_i;
  assign src[5] = src_c2_r1_i;
  assign src[6] = src_c0_r2_i;
  assign src[7] = src_c1_r2_i;
  assign src[8] = src_c2_r2_i;

  // Index wrap: a 5-bit index is below twice the palette size, so one
  // compare and subtract gives the remainder.
  always_comb begin
    logic [8:0] w;
    for (int k = 0; k < psd_pkg::NumSrc; k++) begin
      w = {4'b0, src[k][4:0]};
      if (w >= 9'(PALETTE_ENTRIES)) begin
        w = w - 9'(PALETTE_ENTRIES);
      end
      raddr[k] = w[AddrW-1:0];
    end
    w = {4'b0, src_c0_r0_i[4:0]};
    if (w >= 9'(PALETTE_ENTRIES)) begin
      w = w - 9'(PALETTE_ENTRIES);
    end
    waddr = w[AddrW-1:0];
  end

  // Palette copies, one per read lane, all written together.
  for (genvar k = 0; k < psd_pkg::NumSrc; k++) begin : g_pal
    psd_ram #(
      .WIDTH(24),
      .DEPTH(PALETTE_ENTRIES)
    ) u_pal (
      .clk_i  (clk_i),
      .we_i   (pal_we),
      .waddr_i(waddr),
      .wdata_i(overlay_word_i[23:0]),
      .re_i   (ld1),
      .raddr_i(raddr[k]),
      .rdata_o(rdata[k])
    );
    assign ent[k] = psd_pkg::pal_entry_t'(rdata[k]);
  end

  // Pipeline valid flags; palette writes enter as bubbles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_acc && (opcode_i == psd_pkg::OpPixel);
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) vo_q <= v3_q;
    end
  end

  // Overlay word follows the pixel down the pipeline.
  always_ff @(posedge clk_i) begin
    if (ld1) ovl1_q <= psd_pkg::ovl_t'(overlay_word_i);
    if (ld2) ovl2_q <= ovl1_q;
  end

  // Column lanes: red from column 0, green from 1, blue from 2.
  psd_lane u_lane_r (
    .clk_i (clk_i),
    .ld_i  (ld2),
    .row0_i(ent[0].red),
    .row1_i(ent[3].red),
    .row2_i(ent[6].red),
    .avg_o (avg[0])
  );

  psd_lane u_lane_g (
    .clk_i (clk_i),
    .ld_i  (ld2),
    .row0_i(ent[1].green),
    .row1_i(ent[4].green),
    .row2_i(ent[7].green),
    .avg_o (avg[1])
  );

  psd_lane u_lane_b (
    .clk_i (clk_i),
    .ld_i  (ld2),
    .row0_i(ent[2].blue),
    .row1_i(ent[5].blue),
    .row2_i(ent[8].blue),
    .avg_o (avg[2])
  );

  // Merge lane results or the packed 2x2 average.
  psd_merge u_merge (
    .clk_i  (clk_i),
    .ld_i   (ld2),
    .mode_i (scale_mode_q),
    .e00_i  (ent[0]),
    .e10_i  (ent[1]),
    .e01_i  (ent[3]),
    .e11_i  (ent[4]),
    .avg_r_i(avg[0]),
    .avg_g_i(avg[1]),
    .avg_b_i(avg[2]),
    .col_o  (col)
  );

  // Optional overlay blend.
  psd_blend u_blend (
    .clk_i   (clk_i),
    .ld_i    (ld3),
    .enable_i(overlay_enable_q),
    .col_i   (col),
    .ovl_i   (ovl2_q),
    .pixel_o (pix)
  );

  // Output register with the two bytes swapped.
  always_ff @(posedge clk_i) begin
    if (ld4) begin
      pixel_q <= {pix[7:0], pix[15:8]};
    end
  end

  assign out_valid_o = vo_q;
  assign pixel_out_o = pixel_q;

endmodule

### sv/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the palette subpixel downscaler, bound to its top.
// ----------------------------------------------------------------------------
module psd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] pixel_out_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // No output word is offered while reset is applied.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output word valid during reset");

  // With the output empty the whole pipeline can move, so input is taken.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output");

  // A stalled output word stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped before it was taken");

  // A stalled output word keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pixel_out_o))
    else $error("output word changed while stalled");

  // A written register reads back its new value.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready
    |=> (paddr[2] != $past(paddr[2])) || (prdata[0] == $past(pwdata[0])))
    else $error("configuration readback mismatch");

endmodule

bind palette_subpixel_downscaler_top psd_checker u_psd_checker (.*);

### tb/sv/palette_subpixel_downscaler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_subpixel_downscaler_top_tb
// Self-checking testbench for the palette subpixel downscaler. It loads the
// palette through palette-write words, sends pixel words in both scale modes
// with and without the overlay blend, predicts every byte-swapped RGB565
// output word and compares it with what the block returns, under random
// idling on the input and output channels.
// ----------------------------------------------------------------------------
module palette_subpixel_downscaler_top_tb;

  localparam int unsigned PalEntries  = 32;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RunLimitNs  = 3_000_000;

  // One input word as the sender sees it; src[c + 3*r] is column c, row r.
  typedef struct packed {
    logic                           opcode;
    logic [psd_pkg::NumSrc-1:0][7:0] src;
    logic [31:0]                    ovl;
  } pix_word_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b1;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        opcode_i       = 1'b0;
  logic [7:0]  src_c0_r0_i    = '0;
  logic [7:0]  src_c1_r0_i    = '0;
  logic [7:0]  src_c2_r0_i    = '0;
  logic [7:0]  src_c0_r1_i    = '0;
  logic [7:0]  src_c1_r1_i    = '0;
  logic [7:0]  src_c2_r1_i    = '0;
  logic [7:0]  src_c0_r2_i    = '0;
  logic [7:0]  src_c1_r2_i    = '0;
  logic [7:0]  src_c2_r2_i    = '0;
  logic [31:0] overlay_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [15:0] pixel_out_o;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: palette copy, which entries hold a color, and registers.
  psd_pkg::pal_entry_t pal_model   [PalEntries];
  bit                  pal_written [PalEntries];
  logic                scale_mode_q = psd_pkg::ModeSubpixel;
  logic                ovl_en_q     = 1'b0;

  logic [15:0] expected_pixels [$];
  logic [15:0] want_pixel;

  int unsigned errors         = 0;
  int unsigned pixels_checked = 0;
  int unsigned palette_loads  = 0;
  int unsigned reg_writes     = 0;
  int unsigned in_idle_pct    = 0;
  int unsigned out_idle_pct   = 0;
  int unsigned stall_left     = 0;

  palette_subpixel_downscaler_top #(
    .PALETTE_ENTRIES(PalEntries)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .src_c0_r0_i   (src_c0_r0_i),
    .src_c1_r0_i   (src_c1_r0_i),
    .src_c2_r0_i   (src_c2_r0_i),
    .src_c0_r1_i   (src_c0_r1_i),
    .src_c1_r1_i   (src_c1_r1_i),
    .src_c2_r1_i   (src_c2_r1_i),
    .src_c0_r2_i   (src_c0_r2_i),
    .src_c1_r2_i   (src_c1_r2_i),
    .src_c2_r2_i   (src_c2_r2_i),
    .overlay_word_i(overlay_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_out_o   (pixel_out_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Free-running clock, 12 ns period.
  always #6 clk_i = ~clk_i;

  // Palette slot addressed by an 8-bit index; only the low 5 bits count.
  function automatic int unsigned pal_slot(input logic [7:0] idx);
    return int'(idx[4:0]) % PalEntries;
  endfunction

  // Color component c of an entry: 0 red, 1 green, 2 blue.
  function automatic int unsigned comp(input psd_pkg::pal_entry_t e,
                                       input int unsigned c);
    logic [23:0] bits;
    bits = e;
    return int'(bits[8*c +: 8]);
  endfunction

  // Expected output word for a pixel word under the current registers.
  function automatic logic [15:0] predict_pixel(input pix_word_t w);
    int unsigned         sum [3];
    int unsigned         col, h0a, h0b, h1a, h1b;
    int unsigned         a, br, bg, bb, r, g, b;
    int unsigned         c, rr;
    psd_pkg::pal_entry_t e00, e10, e01, e11;
    psd_pkg::ovl_t       ov;
    logic [15:0]         c16;
    ov = w.ovl;
    if (scale_mode_q == psd_pkg::ModeSubpixel) begin
      for (c = 0; c < 3; c++) begin
        sum[c] = 0;
        for (rr = 0; rr < 3; rr++) begin
          sum[c] += comp(pal_model[pal_slot(w.src[c + 3*rr])], c);
        end
        sum[c] = sum[c] / 3;
      end
      col = ((sum[0] >> 3) << 11) + ((sum[1] >> 2) << 5) + (sum[2] >> 3);
    end else begin
      // Half-palette words; carries between fields are kept as summed.
      e00 = pal_model[pal_slot(w.src[0])];
      e10 = pal_model[pal_slot(w.src[1])];
      e01 = pal_model[pal_slot(w.src[3])];
      e11 = pal_model[pal_slot(w.src[4])];
      h0a = ((comp(e00, 0) >> 3) << 11) + ((comp(e00, 1) >> 3) << 5);
      h0b = ((comp(e01, 0) >> 3) << 11) + ((comp(e01, 1) >> 3) << 5);
      h1a = ((comp(e10, 1) >> 3) << 5) + (comp(e10, 2) >> 3);
      h1b = ((comp(e11, 1) >> 3) << 5) + (comp(e11, 2) >> 3);
      col = (h0a + h1a + h0b + h1b) >> 2;
    end
    col = col & 32'hffff;
    if (ovl_en_q) begin
      // Expand to 8 bits per channel and mix with alpha forced to a/2+128.
      br  = ((col >> 11) & 32'h1f) << 3;
      bg  = ((col >> 5) & 32'h3f) << 2;
      bb  = (col & 32'h1f) << 3;
      a   = int'(ov.alpha) / 2 + 128;
      r   = br * (256 - a) + int'(ov.red) * a;
      g   = bg * (256 - a) + int'(ov.green) * a;
      b   = bb * (256 - a) + int'(ov.blue) * a;
      col = (((r >> 11) << 11) + ((g >> 10) << 5) + (b >> 11)) & 32'hffff;
    end
    c16 = col[15:0];
    return {c16[7:0], c16[15:8]};
  endfunction

  // Random index that lands on a palette entry already holding a color.
  function automatic logic [7:0] pick_index();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while (!pal_written[pal_slot(v)]) v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic pix_word_t pixel_word(input logic [psd_pkg::NumSrc-1:0][7:0] s,
                                           input logic [31:0] ov);
    pix_word_t w;
    w.opcode = psd_pkg::OpPixel;
    w.src    = s;
    w.ovl    = ov;
    return w;
  endfunction

  // Palette write; the index fields other than column 0 row 0 carry noise.
  function automatic pix_word_t pal_word(input logic [7:0] entry, input logic [31:0] rgb);
    pix_word_t   w;
    int unsigned k;
    w.opcode = psd_pkg::OpPalWrite;
    for (k = 0; k < psd_pkg::NumSrc; k++) w.src[k] = 8'($urandom_range(0, 255));
    w.src[0] = entry;
    w.ovl    = rgb;
    return w;
  endfunction

  // Sends one word, with an optional idle burst first, and records its effect.
  task automatic send_word(input pix_word_t w);
    int unsigned gap;
    @(negedge clk_i);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= w.opcode;
    {src_c2_r2_i, src_c1_r2_i, src_c0_r2_i,
     src_c2_r1_i, src_c1_r1_i, src_c0_r1_i,
     src_c2_r0_i, src_c1_r0_i, src_c0_r0_i} <= w.src;
    overlay_word_i <= w.ovl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (w.opcode == psd_pkg::OpPalWrite) begin
      pal_model[pal_slot(w.src[0])]   = w.ovl[23:0];
      pal_written[pal_slot(w.src[0])] = 1'b1;
      palette_loads++;
    end else begin
      expected_pixels.push_back(predict_pixel(w));
    end
  endtask

  // Stops sending, waits for every expected word, then lets the pipe empty.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes one register over APB and reads it back.
  task automatic write_reg(input logic idx, input logic val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'b0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == psd_pkg::RegScaleMode) scale_mode_q = val;
    else ovl_en_q = val;
    reg_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {31'b0, val}) begin
      $display("%0t: register %0d read back: expected %h, actual %h", $time, idx,
               {31'b0, val}, rd);
      errors++;
    end
  endtask

  // Sets both registers; only called while the block is idle.
  task automatic set_mode(input logic mode, input logic ovl_en);
    write_reg(psd_pkg::RegScaleMode, mode);
    write_reg(psd_pkg::RegOverlayEnable, ovl_en);
  endtask

  // Output side: random stall bursts on out_ready_i.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compares each output word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: output word with none expected: expected none, actual %h",
                 $time, pixel_out_o);
        errors++;
      end else begin
        want_pixel = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel_out_o !== want_pixel) begin
          $display("%0t: pixel_out mismatch: expected %h, actual %h", $time,
                   want_pixel, pixel_out_o);
          errors++;
        end
      end
    end
  end

  // A handful of palette entries for the directed words, including indexes
  // above the palette size and ignored upper bytes.
  task automatic test_palette_writes();
    send_word(pal_word(8'h00, 32'hffff_0000 & 32'hff00_0000));
    send_word(pal_word(8'h1f, 32'h00ff_ffff));
    send_word(pal_word(8'he5, 32'ha57f_40c3));
    send_word(pal_word(8'h2a, 32'hfff8_07f9));
  endtask

  // Subpixel averaging: black, white, index wrap and mixed columns.
  task automatic test_subpixel();
    wait_drained();
    set_mode(psd_pkg::ModeSubpixel, 1'b0);
    send_word(pixel_word({9{8'h00}}, 32'h0000_0000));
    send_word(pixel_word({9{8'hff}}, 32'hffff_ffff));
    send_word(pixel_word({9{8'he5}}, 32'h1234_5678));
    send_word(pixel_word({8'hff, 8'h00, 8'h1f, 8'he0, 8'h2a, 8'h05,
                          8'h0a, 8'h1f, 8'h00}, 32'h0000_0000));
    send_word(pixel_word({8'h2a, 8'he5, 8'h1f, 8'h0a, 8'h05, 8'hff,
                          8'h2a, 8'he0, 8'h05}, 32'hffff_ffff));
  endtask

  // Packed averaging, with carries between the packed fields.
  task automatic test_packed();
    wait_drained();
    set_mode(psd_pkg::ModePacked, 1'b0);
    send_word(pixel_word({9{8'h1f}}, 32'h0000_0000));
    send_word(pixel_word({9{8'h00}}, 32'hffff_ffff));
    send_word(pixel_word({8'h00, 8'h00, 8'h00, 8'h00, 8'h2a, 8'hff,
                          8'h00, 8'h0a, 8'hff}, 32'h0000_0000));
    send_word(pixel_word({8'hff, 8'h1f, 8'he0, 8'hff, 8'he5, 8'h2a,
                          8'h00, 8'h05, 8'h0a}, 32'h5555_aaaa));
  endtask

  // Overlay blend at the alpha extremes in both modes.
  task automatic test_overlay();
    wait_drained();
    set_mode(psd_pkg::ModeSubpixel, 1'b1);
    send_word(pixel_word({9{8'h00}}, 32'h00ff_ffff));
    send_word(pixel_word({9{8'hff}}, 32'hff00_0000));
    send_word(pixel_word({9{8'he5}}, 32'h7f80_40c0));
    wait_drained();
    set_mode(psd_pkg::ModePacked, 1'b1);
    send_word(pixel_word({9{8'h1f}}, 32'h0000_0000));
    send_word(pixel_word({9{8'h2a}}, 32'hffff_ffff));
  endtask

  // Random words in one register setting; some stretches run without idling.
  task automatic test_random_phase(input logic mode, input logic ovl_en,
                                   input int unsigned n_words,
                                   input int unsigned idle_pct);
    int unsigned k, j;
    pix_word_t   w;
    wait_drained();
    set_mode(mode, ovl_en);
    for (k = 0; k < n_words; k++) begin
      in_idle_pct  = ((k % 50) < 12) ? 0 : idle_pct;
      out_idle_pct = ((k % 50) < 12) ? 0 : idle_pct;
      if ($urandom_range(0, 99) < 25) begin
        w = pal_word(8'($urandom_range(0, 255)), $urandom);
      end else begin
        w.opcode = psd_pkg::OpPixel;
        for (j = 0; j < psd_pkg::NumSrc; j++) w.src[j] = pick_index();
        w.ovl = $urandom;
      end
      send_word(w);
    end
  endtask

  // Final stretch with no idling on either side.
  task automatic test_full_rate();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 30, 0);
  endtask

  // Test sequence.
  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_palette_writes();
    test_subpixel();
    test_packed();
    test_overlay();
    test_random_phase(psd_pkg::ModeSubpixel, 1'b0, 130, 30);
    test_random_phase(psd_pkg::ModePacked,   1'b0, 130, 30);
    test_random_phase(psd_pkg::ModeSubpixel, 1'b1, 130, 40);
    test_random_phase(psd_pkg::ModePacked,   1'b1, 100, 20);
    test_full_rate();
    wait_drained();
    $display("Checked %0d output pixels after %0d palette loads and %0d register writes,",
             pixels_checked, palette_loads, reg_writes);
    $display("covering both scale modes with the overlay blend off and on.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RunLimitNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule
